/* design/mlc_pkg.sv */
// ----------------------------------------------------------------------------
// mlc_pkg
// Types, constants and outcode bit values for the midpoint line clipper.
// ----------------------------------------------------------------------------
`default_nettype none
package mlc_pkg;
	localparam int COORD_BITS_DEF = 16;
	localparam int IO_BITS        = 16;
	localparam int THR_BITS       = 33;
	localparam int CFG_IDX_BITS   = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_WIN_LEFT   = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_WIN_RIGHT  = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_WIN_BOTTOM = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_WIN_TOP    = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_STOP_THR   = 3'd4;

	localparam logic [15:0] WIN_LEFT_RST   = 16'd13107;
	localparam logic [15:0] WIN_RIGHT_RST  = 16'd52429;
	localparam logic [15:0] WIN_BOTTOM_RST = 16'd19661;
	localparam logic [15:0] WIN_TOP_RST    = 16'd45875;
	localparam logic [THR_BITS-1:0] STOP_THR_RST = 33'd858993459;

	localparam logic [3:0] OC_LEFT   = 4'd1;
	localparam logic [3:0] OC_RIGHT  = 4'd2;
	localparam logic [3:0] OC_BOTTOM = 4'd4;
	localparam logic [3:0] OC_TOP    = 4'd8;

	typedef enum logic [1:0] {
		CASE_ACCEPT    = 2'd0,
		CASE_REJECT    = 2'd1,
		CASE_SUBDIVIDE = 2'd2
	} clip_case_t;

	typedef struct packed {
		logic [15:0] start_x;
		logic [15:0] start_y;
		logic [15:0] end_x;
		logic [15:0] end_y;
	} seg_req_t;

	typedef struct packed {
		logic        visible;
		logic [15:0] clip_start_x;
		logic [15:0] clip_start_y;
		logic [15:0] clip_end_x;
		logic [15:0] clip_end_y;
		logic [1:0]  clip_case;
	} seg_res_t;
endpackage
`default_nettype wire

/* design/mlc_bisect_stage.sv */
// ----------------------------------------------------------------------------
// mlc_bisect_stage
// One registered bisection step: midpoint, outcode, squared-length stop test.
// ----------------------------------------------------------------------------
`default_nettype none
module mlc_bisect_stage #(
	parameter int CB = mlc_pkg::COORD_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [CB-1:0]                 wl,
	input  wire logic [CB-1:0]                 wr,
	input  wire logic [CB-1:0]                 wb,
	input  wire logic [CB-1:0]                 wt,
	input  wire logic [mlc_pkg::THR_BITS-1:0]  thr,
	input  wire logic                          in_act,
	input  wire logic [CB-1:0]                 in_ox,
	input  wire logic [CB-1:0]                 in_oy,
	input  wire logic [CB-1:0]                 in_tx,
	input  wire logic [CB-1:0]                 in_ty,
	input  wire logic [3:0]                    in_co,
	input  wire logic                          in_seen,
	output logic                               out_act,
	output logic [CB-1:0]                      out_ox,
	output logic [CB-1:0]                      out_oy,
	output logic [CB-1:0]                      out_tx,
	output logic [CB-1:0]                      out_ty,
	output logic [3:0]                         out_co,
	output logic                               out_seen
);
	localparam int SQW = 2 * CB;
	localparam int SUMW = (SQW > 32 ? SQW : 32) + 1;

	logic [CB:0]   sum_x, sum_y;
	logic [CB-1:0] mx, my, nox, noy, ntx, nty, dx, dy;
	logic [3:0]    cm;
	logic          take;
	logic [SQW-1:0] sqx, sqy;
	logic [SUMW-1:0] ax, ay, len_sq;

	always_comb begin
		sum_x = {1'b0, in_ox} + {1'b0, in_tx};
		sum_y = {1'b0, in_oy} + {1'b0, in_ty};
		mx = sum_x[CB:1];
		my = sum_y[CB:1];
		cm = 4'd0;
		if (mx < wl) cm = cm | mlc_pkg::OC_LEFT;
		else if (mx > wr) cm = cm | mlc_pkg::OC_RIGHT;
		if (my > wt) cm = cm | mlc_pkg::OC_TOP;
		else if (my < wb) cm = cm | mlc_pkg::OC_BOTTOM;
		take = (in_co & cm) != 4'd0;
		nox = take ? mx : in_ox;
		noy = take ? my : in_oy;
		ntx = take ? in_tx : mx;
		nty = take ? in_ty : my;
		dx = nox > ntx ? nox - ntx : ntx - nox;
		dy = noy > nty ? noy - nty : nty - noy;
		sqx = {{CB{1'b0}}, dx} * {{CB{1'b0}}, dx};
		sqy = {{CB{1'b0}}, dy} * {{CB{1'b0}}, dy};
		if (CB >= 16) begin
			ax = SUMW'(sqx >> (2 * CB - 32));
			ay = SUMW'(sqy >> (2 * CB - 32));
		end else begin
			ax = SUMW'(sqx) << (32 - 2 * CB);
			ay = SUMW'(sqy) << (32 - 2 * CB);
		end
		len_sq = ax + ay;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_act <= 1'b0;
		end else begin
			out_act <= in_act && !(len_sq < SUMW'(thr));
		end
	end

	always_ff @(posedge clk) begin
		if (in_act) begin
			out_ox <= nox;
			out_oy <= noy;
			out_tx <= ntx;
			out_ty <= nty;
			out_co <= take ? cm : in_co;
			out_seen <= in_seen | (cm == 4'd0);
		end else begin
			out_ox <= in_ox;
			out_oy <= in_oy;
			out_tx <= in_tx;
			out_ty <= in_ty;
			out_co <= in_co;
			out_seen <= in_seen;
		end
	end
endmodule
`default_nettype wire

/* design/midpoint_line_clipper.sv */
// ----------------------------------------------------------------------------
// midpoint_line_clipper
// Midpoint subdivision clipping of one segment against a configured window.
// ----------------------------------------------------------------------------
// Usage: drive req and pulse start while busy is low; one request is taken
// per cycle. Stage 1 widens coordinates and computes outcodes. Then the start
// endpoint runs through COORD_BITS+1 bisection stages, then the end endpoint
// through another COORD_BITS+1 stages, one halving per stage; a finished
// search passes its values through unchanged. A final stage registers the
// result. Throughput is one request per cycle, busy stays low. The result is
// on res for one cycle with done high; the receiver cannot stall.
// Configuration writes through cfg_we/cfg_idx/cfg_data take effect at once;
// the user must make them only while idle, which the block does not enforce.
// Reset clears all valid bits and loads the default window and threshold.
// ----------------------------------------------------------------------------
`default_nettype none
module midpoint_line_clipper #(
	parameter int COORD_BITS = mlc_pkg::COORD_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire mlc_pkg::seg_req_t                req,
	output logic                                  done,
	output mlc_pkg::seg_res_t                     res,
	input  wire logic                             cfg_we,
	input  wire logic [mlc_pkg::CFG_IDX_BITS-1:0] cfg_idx,
	input  wire logic [mlc_pkg::THR_BITS-1:0]     cfg_data
);
	localparam int CB = COORD_BITS;
	localparam int NS = CB + 1;

	logic [15:0] wl_q, wr_q, wb_q, wt_q;
	logic [mlc_pkg::THR_BITS-1:0] thr_q;
	logic [CB-1:0] wl, wr, wb, wt;

	function automatic logic [CB-1:0] widen(input logic [15:0] v);
		if (CB >= 16) return CB'({v, {(CB > 16 ? CB - 16 : 1){1'b0}}} >> (CB > 16 ? 0 : 1));
		else return CB'(v >> (16 - CB));
	endfunction

	function automatic logic [15:0] narrow(input logic [CB-1:0] v);
		if (CB >= 16) return 16'(v >> (CB - 16));
		else return 16'({v, {(CB < 16 ? 16 - CB : 1){1'b0}}} >> (CB < 16 ? 0 : 1));
	endfunction

	function automatic logic [3:0] ocode(input logic [CB-1:0] x, input logic [CB-1:0] y,
			input logic [CB-1:0] l, input logic [CB-1:0] r,
			input logic [CB-1:0] b, input logic [CB-1:0] t);
		logic [3:0] c;
		c = 4'd0;
		if (x < l) c = c | mlc_pkg::OC_LEFT;
		else if (x > r) c = c | mlc_pkg::OC_RIGHT;
		if (y > t) c = c | mlc_pkg::OC_TOP;
		else if (y < b) c = c | mlc_pkg::OC_BOTTOM;
		return c;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q <= mlc_pkg::WIN_LEFT_RST;
			wr_q <= mlc_pkg::WIN_RIGHT_RST;
			wb_q <= mlc_pkg::WIN_BOTTOM_RST;
			wt_q <= mlc_pkg::WIN_TOP_RST;
			thr_q <= mlc_pkg::STOP_THR_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				mlc_pkg::REG_WIN_LEFT:   wl_q <= cfg_data[15:0];
				mlc_pkg::REG_WIN_RIGHT:  wr_q <= cfg_data[15:0];
				mlc_pkg::REG_WIN_BOTTOM: wb_q <= cfg_data[15:0];
				mlc_pkg::REG_WIN_TOP:    wt_q <= cfg_data[15:0];
				mlc_pkg::REG_STOP_THR:   thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign wl = widen(wl_q);
	assign wr = widen(wr_q);
	assign wb = widen(wb_q);
	assign wt = widen(wt_q);
	assign busy = 1'b0;

	// stage 1: widen and classify
	logic v_s1;
	logic [CB-1:0] sx_s1, sy_s1, ex_s1, ey_s1;
	logic [3:0] cs_s1, ce_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		sx_s1 <= widen(req.start_x);
		sy_s1 <= widen(req.start_y);
		ex_s1 <= widen(req.end_x);
		ey_s1 <= widen(req.end_y);
		cs_s1 <= ocode(widen(req.start_x), widen(req.start_y), wl, wr, wb, wt);
		ce_s1 <= ocode(widen(req.end_x), widen(req.end_y), wl, wr, wb, wt);
	end

	// bisection chain: stages 0..NS-1 start endpoint, NS..2NS-1 end endpoint
	localparam int NT = 2 * NS;
	logic          v_c [NT+1];
	logic          a_c [NT+1];
	logic [CB-1:0] ox_c [NT+1], oy_c [NT+1], tx_c [NT+1], ty_c [NT+1];
	logic [3:0]    co_c [NT+1];
	logic          sn_c [NT+1];
	logic [CB-1:0] sx_c [NT+1], sy_c [NT+1], ex_c [NT+1], ey_c [NT+1];
	logic [3:0]    cs_c [NT+1], ce_c [NT+1];
	logic [CB-1:0] rsx_c [NT+1], rsy_c [NT+1];

	logic sub_s1;
	assign sub_s1 = ((cs_s1 | ce_s1) != 4'd0) && ((cs_s1 & ce_s1) == 4'd0);

	assign v_c[0]  = v_s1;
	assign a_c[0]  = sub_s1 && (cs_s1 != 4'd0);
	assign ox_c[0] = sx_s1;
	assign oy_c[0] = sy_s1;
	assign tx_c[0] = ex_s1;
	assign ty_c[0] = ey_s1;
	assign co_c[0] = cs_s1;
	assign sn_c[0] = (cs_s1 == 4'd0) || (ce_s1 == 4'd0);
	assign sx_c[0] = sx_s1;
	assign sy_c[0] = sy_s1;
	assign ex_c[0] = ex_s1;
	assign ey_c[0] = ey_s1;
	assign cs_c[0] = cs_s1;
	assign ce_c[0] = ce_s1;
	assign rsx_c[0] = sx_s1;
	assign rsy_c[0] = sy_s1;

	for (genvar g = 0; g < NT; g++) begin : g_stage
		logic          in_act;
		logic [CB-1:0] ix, iy, itx, ity;
		logic [3:0]    ico;
		logic          o_act;
		logic [CB-1:0] o_x, o_y, o_tx, o_ty;
		logic [3:0]    o_co;
		logic          o_sn;

		if (g == NS) begin : g_switch
			// hold clipped start, load end endpoint search
			assign in_act = ((cs_c[g] | ce_c[g]) != 4'd0) && ((cs_c[g] & ce_c[g]) == 4'd0)
				&& (ce_c[g] != 4'd0);
			assign ix  = ex_c[g];
			assign iy  = ey_c[g];
			assign itx = sx_c[g];
			assign ity = sy_c[g];
			assign ico = ce_c[g];
		end else begin : g_cont
			assign in_act = a_c[g];
			assign ix  = ox_c[g];
			assign iy  = oy_c[g];
			assign itx = tx_c[g];
			assign ity = ty_c[g];
			assign ico = co_c[g];
		end

		mlc_bisect_stage #(.CB(CB)) u_step (
			.clk(clk), .arst_n(arst_n),
			.wl(wl), .wr(wr), .wb(wb), .wt(wt), .thr(thr_q),
			.in_act(in_act && v_c[g]),
			.in_ox(ix), .in_oy(iy), .in_tx(itx), .in_ty(ity),
			.in_co(ico), .in_seen(sn_c[g]),
			.out_act(o_act), .out_ox(o_x), .out_oy(o_y), .out_tx(o_tx), .out_ty(o_ty),
			.out_co(o_co), .out_seen(o_sn)
		);

		assign a_c[g+1]  = o_act;
		assign ox_c[g+1] = o_x;
		assign oy_c[g+1] = o_y;
		assign tx_c[g+1] = o_tx;
		assign ty_c[g+1] = o_ty;
		assign co_c[g+1] = o_co;
		assign sn_c[g+1] = o_sn;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_c[g+1] <= 1'b0;
			else v_c[g+1] <= v_c[g];
		end

		always_ff @(posedge clk) begin
			sx_c[g+1] <= sx_c[g];
			sy_c[g+1] <= sy_c[g];
			ex_c[g+1] <= ex_c[g];
			ey_c[g+1] <= ey_c[g];
			cs_c[g+1] <= cs_c[g];
			ce_c[g+1] <= ce_c[g];
			if (g == NS) begin
				rsx_c[g+1] <= ox_c[g];
				rsy_c[g+1] <= oy_c[g];
			end else begin
				rsx_c[g+1] <= rsx_c[g];
				rsy_c[g+1] <= rsy_c[g];
			end
		end
	end

	// output stage
	logic v_out_s;
	mlc_pkg::seg_res_t res_out_s;
	logic [3:0] fcs, fce;
	logic f_vis;
	mlc_pkg::clip_case_t f_case;

	always_comb begin
		fcs = cs_c[NT];
		fce = ce_c[NT];
		if ((fcs | fce) == 4'd0) begin
			f_vis = 1'b1;
			f_case = mlc_pkg::CASE_ACCEPT;
		end else if ((fcs & fce) != 4'd0) begin
			f_vis = 1'b0;
			f_case = mlc_pkg::CASE_REJECT;
		end else begin
			f_vis = sn_c[NT];
			f_case = mlc_pkg::CASE_SUBDIVIDE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_out_s <= 1'b0;
		else v_out_s <= v_c[NT];
	end

	always_ff @(posedge clk) begin
		res_out_s.visible      <= f_vis;
		res_out_s.clip_start_x <= f_vis ? narrow(rsx_c[NT]) : 16'd0;
		res_out_s.clip_start_y <= f_vis ? narrow(rsy_c[NT]) : 16'd0;
		res_out_s.clip_end_x   <= f_vis ? narrow(ox_c[NT]) : 16'd0;
		res_out_s.clip_end_y   <= f_vis ? narrow(oy_c[NT]) : 16'd0;
		res_out_s.clip_case    <= f_case;
	end

	assign done = v_out_s;
	assign res  = res_out_s;
endmodule
`default_nettype wire

/* design/mlc_checker.sv */
// ----------------------------------------------------------------------------
// mlc_checker
// Port-level checks for the midpoint line clipper.
// ----------------------------------------------------------------------------
`default_nettype none
module mlc_checker #(
	parameter int CB = mlc_pkg::COORD_BITS_DEF
) (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic              done,
	input wire mlc_pkg::seg_res_t res
);
	localparam int LAT = 2 * CB + 4;

	a_case: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> res.clip_case != 2'd3) else $error("bad clip case");
	a_hidden: assert property (@(posedge clk) disable iff (!arst_n)
		done && !res.visible |-> res.clip_start_x == 16'd0 && res.clip_end_y == 16'd0)
		else $error("hidden segment has coordinates");
	a_acc: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.clip_case == mlc_pkg::CASE_ACCEPT |-> res.visible)
		else $error("accepted not visible");
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done) else $error("result missing");
endmodule

bind midpoint_line_clipper mlc_checker #(.CB(COORD_BITS)) u_mlc_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .res(res)
);
`default_nettype wire
